// ----- hdl/lif_pkg.sv -----
// ----------------------------------------------------------------------------
// LIF neuron package
// Types, register codes and reset values shared by the LIF neuron modules.
// ----------------------------------------------------------------------------
package lif_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int NOISE_W   = 41;
    localparam int DRIVE_W   = 39;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DECAY_FACTOR     = 3'd0,
        CFG_INPUT_GAIN       = 3'd1,
        CFG_INPUT_CURRENT    = 3'd2,
        CFG_SPIKE_THRESHOLD  = 3'd3,
        CFG_RESET_POTENTIAL  = 3'd4,
        CFG_REFRACTORY_STEPS = 3'd5,
        CFG_NOISE_ENABLE     = 3'd6,
        CFG_NOISE_WEIGHT     = 3'd7
    } cfg_reg_e;

    localparam logic CMD_TICK    = 1'b0;
    localparam logic CMD_RECEIVE = 1'b1;

    localparam logic [16:0]        RST_DECAY_FACTOR     = 17'd65209;
    localparam logic [21:0]        RST_INPUT_GAIN       = 22'd6537;
    localparam logic signed [31:0] RST_INPUT_CURRENT    = 32'sd0;
    localparam logic signed [31:0] RST_SPIKE_THRESHOLD  = 32'sd1310720;
    localparam logic signed [31:0] RST_RESET_POTENTIAL  = 32'sd655360;
    localparam logic [15:0]        RST_REFRACTORY_STEPS = 16'd20;
    localparam logic               RST_NOISE_ENABLE     = 1'b1;
    localparam logic signed [31:0] RST_NOISE_WEIGHT     = 32'sd6554;

    typedef struct packed {
        logic               cmd;
        logic [7:0]         noise_count;
        logic [31:0]        arrival_time;
        logic signed [31:0] weight;
    } in_item_t;

    typedef struct packed {
        logic               spiked;
        logic signed [31:0] potential_out;
        logic [31:0]        spike_total;
        logic [31:0]        last_spike_step;
    } out_item_t;

    typedef struct packed {
        logic [16:0]               decay_factor;
        logic signed [DRIVE_W-1:0] drive_term;
        logic signed [31:0]        spike_threshold;
        logic signed [31:0]        reset_potential;
        logic [15:0]               refractory_steps;
        logic                      noise_enable;
        logic signed [31:0]        noise_weight;
    } cfg_t;

    typedef struct packed {
        logic                      cmd;
        logic signed [31:0]        weight;
        logic signed [NOISE_W-1:0] noise_term;
        logic [31:0]               step;
    } stage_t;

endpackage

// ----- hdl/lif_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// LIF configuration registers
// Holds the neuron registers and the registered product of current and gain.
// ----------------------------------------------------------------------------
module lif_cfg_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [lif_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [31:0]                         wr_data,
    output lif_pkg::cfg_t                       cfg
);

    logic [16:0]        decay_reg;
    logic [21:0]        gain_reg;
    logic signed [31:0] current_reg;
    logic signed [31:0] threshold_reg;
    logic signed [31:0] reset_pot_reg;
    logic [15:0]        refr_steps_reg;
    logic               noise_en_reg;
    logic signed [31:0] noise_weight_reg;
    logic signed [lif_pkg::DRIVE_W-1:0] drive_reg;
    logic signed [54:0] drive_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg        <= lif_pkg::RST_DECAY_FACTOR;
            gain_reg         <= lif_pkg::RST_INPUT_GAIN;
            current_reg      <= lif_pkg::RST_INPUT_CURRENT;
            threshold_reg    <= lif_pkg::RST_SPIKE_THRESHOLD;
            reset_pot_reg    <= lif_pkg::RST_RESET_POTENTIAL;
            refr_steps_reg   <= lif_pkg::RST_REFRACTORY_STEPS;
            noise_en_reg     <= lif_pkg::RST_NOISE_ENABLE;
            noise_weight_reg <= lif_pkg::RST_NOISE_WEIGHT;
        end
        else if (wr_en)
        begin
            case (lif_pkg::cfg_reg_e'(wr_index))
                lif_pkg::CFG_DECAY_FACTOR:     decay_reg        <= wr_data[16:0];
                lif_pkg::CFG_INPUT_GAIN:       gain_reg         <= wr_data[21:0];
                lif_pkg::CFG_INPUT_CURRENT:    current_reg      <= $signed(wr_data);
                lif_pkg::CFG_SPIKE_THRESHOLD:  threshold_reg    <= $signed(wr_data);
                lif_pkg::CFG_RESET_POTENTIAL:  reset_pot_reg    <= $signed(wr_data);
                lif_pkg::CFG_REFRACTORY_STEPS: refr_steps_reg   <= wr_data[15:0];
                lif_pkg::CFG_NOISE_ENABLE:     noise_en_reg     <= wr_data[0];
                lif_pkg::CFG_NOISE_WEIGHT:     noise_weight_reg <= $signed(wr_data);
                default:                       ;
            endcase
        end
    end

    // The current-times-gain term is constant between writes, so it is
    // formed here once and registered, floored to Q16.16.
    assign drive_prod = current_reg * $signed({1'b0, gain_reg});

    always_ff @(posedge clk)
    begin
        drive_reg <= drive_prod[54:16];
    end

    always_comb
    begin
        cfg.decay_factor     = decay_reg;
        cfg.drive_term       = drive_reg;
        cfg.spike_threshold  = threshold_reg;
        cfg.reset_potential  = reset_pot_reg;
        cfg.refractory_steps = refr_steps_reg;
        cfg.noise_enable     = noise_en_reg;
        cfg.noise_weight     = noise_weight_reg;
    end

endmodule

// ----- hdl/lif_delay_ring.sv -----
// ----------------------------------------------------------------------------
// LIF delay ring
// Slot memory with one write and one registered read port, write-to-read
// forwarding and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module lif_delay_ring
#(
    parameter int RING_DEPTH = 16,
    parameter int AW         = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  logic signed [31:0]  wr_data,
    output logic signed [31:0]  rd_data,
    output logic                clearing
);

    logic signed [31:0] mem [RING_DEPTH];
    logic signed [31:0] rd_data_reg;
    logic               clear_reg;
    logic [AW-1:0]      clear_addr_reg;
    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [31:0] wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_addr_reg <= clear_addr_reg + AW'(1);
            if (clear_addr_reg == AW'(RING_DEPTH - 1))
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    assign we    = clear_reg || wr_en;
    assign waddr = clear_reg ? clear_addr_reg : wr_addr;
    assign wdata = clear_reg ? 32'sd0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            if (we && (waddr == rd_addr))
            begin
                rd_data_reg <= wdata;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clear_reg;

    a_no_access_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> (!rd_en && !wr_en))
        else $error("delay ring accessed during the zeroing sweep");

endmodule

// ----- hdl/lif_front.sv -----
// ----------------------------------------------------------------------------
// LIF front stage
// Registers each accepted item with its noise term, step index and slot
// quotient, and forms the ring slot address for the memory read.
// ----------------------------------------------------------------------------
module lif_front
#(
    parameter int RING_DEPTH = 16,
    parameter int AW         = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 accept,
    input  lif_pkg::in_item_t    in_item,
    input  lif_pkg::cfg_t        cfg,
    output logic                 s0_valid,
    output lif_pkg::stage_t      s0_stage,
    output logic [AW-1:0]        s0_addr
);

    localparam int          SH    = 32 + AW;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(RING_DEPTH) - 64'd1)
                                    / 64'(RING_DEPTH);

    logic                s0_valid_reg;
    lif_pkg::stage_t     s0_reg;
    logic [31:0]         s0_arrival_reg;
    logic [31:0]         s0_quot_reg;
    logic [AW-1:0]       s0_tslot_reg;
    logic [31:0]         step_reg;
    logic [AW-1:0]       tslot_reg;
    logic                tick_acc;
    logic [64:0]         quot_prod;
    logic [31:0]         quot;
    logic signed [lif_pkg::NOISE_W-1:0] noise_prod;
    logic [41:0]         back_prod;
    logic [31:0]         rem_raw;
    logic [31:0]         rem;

    assign tick_acc = accept && (in_item.cmd == lif_pkg::CMD_TICK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            step_reg     <= '0;
            tslot_reg    <= '0;
        end
        else
        begin
            if (adv)
            begin
                s0_valid_reg <= accept;
            end
            if (tick_acc)
            begin
                step_reg <= step_reg + 32'd1;
                if (tslot_reg == AW'(RING_DEPTH - 1))
                begin
                    tslot_reg <= '0;
                end
                else
                begin
                    tslot_reg <= tslot_reg + AW'(1);
                end
            end
        end
    end

    assign quot_prod  = 65'(in_item.arrival_time) * 65'(RECIP[32:0]);
    assign quot       = 32'(quot_prod >> SH);
    assign noise_prod = $signed({1'b0, (cfg.noise_enable ? in_item.noise_count : 8'd0)})
                        * cfg.noise_weight;

    always_ff @(posedge clk)
    begin
        if (adv && accept)
        begin
            s0_reg.cmd        <= in_item.cmd;
            s0_reg.weight     <= in_item.weight;
            s0_reg.noise_term <= noise_prod;
            s0_reg.step       <= step_reg;
            s0_arrival_reg    <= in_item.arrival_time;
            s0_quot_reg       <= quot;
            s0_tslot_reg      <= tslot_reg;
        end
    end

    assign back_prod = 42'(s0_quot_reg) * 42'(RING_DEPTH);
    assign rem_raw   = s0_arrival_reg - back_prod[31:0];
    assign rem       = (rem_raw >= 32'(RING_DEPTH)) ? rem_raw - 32'(RING_DEPTH) : rem_raw;

    assign s0_valid = s0_valid_reg;
    assign s0_stage = s0_reg;
    assign s0_addr  = (s0_reg.cmd == lif_pkg::CMD_RECEIVE) ? rem[AW-1:0] : s0_tslot_reg;

endmodule

// ----- hdl/lif_update.sv -----
// ----------------------------------------------------------------------------
// LIF update stage
// Holds neuron state, applies one item per unstalled cycle and registers results.
// ----------------------------------------------------------------------------
module lif_update
#(
    parameter int AW = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 s0_valid,
    input  lif_pkg::stage_t      s0_stage,
    input  logic [AW-1:0]        s0_addr,
    input  logic signed [31:0]   slot_data,
    input  lif_pkg::cfg_t        cfg,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output logic signed [31:0]   wr_data,
    output logic                 out_valid,
    output lif_pkg::out_item_t   out_item
);

    localparam int ACC_W = 44;

    logic                s1_valid_reg;
    lif_pkg::stage_t     s1_reg;
    logic [AW-1:0]       s1_addr_reg;
    logic signed [31:0]  v_reg;
    logic signed [31:0]  v_next;
    logic                refr_reg;
    logic                refr_next;
    logic [15:0]         rcnt_reg;
    logic [15:0]         rcnt_next;
    logic [31:0]         spk_cnt_reg;
    logic [31:0]         spk_cnt_next;
    logic [31:0]         last_reg;
    logic [31:0]         last_next;
    logic                out_valid_reg;
    lif_pkg::out_item_t  out_item_reg;
    logic                fire;
    logic                is_tick;
    logic                spike;
    logic                refr_now;
    logic [15:0]         rcnt_inc;
    logic signed [49:0]  decay_prod;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] ring_sum;

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
        logic upper_same;
        upper_same = (x[ACC_W-1:31] == '0) || (x[ACC_W-1:31] == '1);
        if (upper_same)
        begin
            return x[31:0];
        end
        return x[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    assign fire    = s1_valid_reg && adv;
    assign is_tick = (s1_reg.cmd == lif_pkg::CMD_TICK);

    assign decay_prod = $signed({1'b0, cfg.decay_factor}) * v_reg;
    assign acc        = ACC_W'($signed(decay_prod[49:16])) + ACC_W'(cfg.drive_term)
                        + ACC_W'(slot_data) + ACC_W'(s1_reg.noise_term);
    assign ring_sum   = ACC_W'(slot_data) + ACC_W'(s1_reg.weight);
    assign rcnt_inc   = rcnt_reg + 16'd1;
    assign spike      = is_tick && (v_reg > cfg.spike_threshold);
    assign refr_now   = refr_reg || spike;

    always_comb
    begin
        v_next       = v_reg;
        refr_next    = refr_reg;
        rcnt_next    = rcnt_reg;
        spk_cnt_next = spk_cnt_reg;
        last_next    = last_reg;
        wr_en        = 1'b0;
        wr_data      = 32'sd0;
        if (!is_tick)
        begin
            wr_en   = fire;
            wr_data = sat32(ring_sum);
        end
        else
        begin
            if (spike)
            begin
                spk_cnt_next = spk_cnt_reg + 32'd1;
                last_next    = s1_reg.step;
            end
            if (refr_now)
            begin
                if (rcnt_inc > cfg.refractory_steps)
                begin
                    v_next    = cfg.reset_potential;
                    rcnt_next = '0;
                    refr_next = 1'b0;
                end
                else
                begin
                    v_next    = 32'sd0;
                    rcnt_next = rcnt_inc;
                    refr_next = 1'b1;
                end
            end
            else
            begin
                v_next = sat32(acc);
                wr_en  = fire;
            end
        end
    end

    assign wr_addr = s1_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            v_reg         <= '0;
            refr_reg      <= 1'b0;
            rcnt_reg      <= '0;
            spk_cnt_reg   <= '0;
            last_reg      <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= s0_valid;
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                v_reg       <= v_next;
                refr_reg    <= refr_next;
                rcnt_reg    <= rcnt_next;
                spk_cnt_reg <= spk_cnt_next;
                last_reg    <= last_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg      <= s0_stage;
            s1_addr_reg <= s0_addr;
        end
        if (fire)
        begin
            out_item_reg.spiked          <= spike;
            out_item_reg.potential_out   <= v_next;
            out_item_reg.spike_total     <= spk_cnt_next;
            out_item_reg.last_spike_step <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_receive_keeps_potential : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !is_tick) |=> (v_reg == $past(v_reg)))
        else $error("receive item changed the membrane potential");

    a_spike_counts : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && spike) |=> (spk_cnt_reg == $past(spk_cnt_reg) + 32'd1))
        else $error("spike not counted");

    a_refractory_no_ring_write : assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_tick && refr_reg) |-> !wr_en)
        else $error("ring slot written during a refractory step");

endmodule

// ----- hdl/lif_neuron_delay_ring.sv -----
// ----------------------------------------------------------------------------
// LIF neuron with delay ring
// Leaky integrate-and-fire neuron in Q16.16 with a ring of delayed inputs.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  in        in_valid / in_stall  in_item   (cmd, noise_count, arrival, weight)
//  out       out_valid / out_stall out_item (spiked, potential, totals)
//  cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while in_stall is low; the update stage registers each result.
// The front stage, the slot memory read and the update stage form the pipeline.
// After reset the ring is zeroed slot by slot while in_stall is high.
// A stalled result holds the whole pipeline and raises in_stall.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module lif_neuron_delay_ring
#(
    parameter int RING_DEPTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  lif_pkg::in_item_t                 in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output lif_pkg::out_item_t                out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lif_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);

    lif_pkg::cfg_t       cfg;
    lif_pkg::stage_t     s0_stage;
    logic                s0_valid;
    logic [AW-1:0]       s0_addr;
    logic                adv;
    logic                accept;
    logic                clearing;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic signed [31:0]  wr_data;
    logic signed [31:0]  slot_data;

    assign adv       = !(out_valid && out_stall);
    assign in_stall  = clearing || !adv;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    lif_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    lif_front #(.RING_DEPTH(RING_DEPTH), .AW(AW)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .accept   (accept),
        .in_item  (in_item),
        .cfg      (cfg),
        .s0_valid (s0_valid),
        .s0_stage (s0_stage),
        .s0_addr  (s0_addr)
    );

    lif_delay_ring #(.RING_DEPTH(RING_DEPTH), .AW(AW)) u_ring
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (adv && s0_valid),
        .rd_addr  (s0_addr),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (slot_data),
        .clearing (clearing)
    );

    lif_update #(.AW(AW)) u_update
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s0_valid  (s0_valid),
        .s0_stage  (s0_stage),
        .s0_addr   (s0_addr),
        .slot_data (slot_data),
        .cfg       (cfg),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

endmodule

// ----- bench/lif_neuron_delay_ring_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LIF neuron with delay ring: self-checking testbench
// Drives tick and receive items through the neuron under several register
// settings, extremes among them. Each result is checked field by field
// against a cycle-free model of the neuron held in this file, or for typed
// rows against the table. Both channels idle and stall at random, and the
// output is once stalled long enough to back the pipeline up into the input.
// ----------------------------------------------------------------------------
module lif_neuron_delay_ring_tb;

    localparam int RING_N     = 16;
    localparam int NUM_PHASES = 9;
    localparam int CYCLE_MAX  = 400000;
    localparam int NUM_DIR    = 12;

    typedef struct packed {
        logic               typed;
        lif_pkg::in_item_t  item;
        lif_pkg::out_item_t res;
    } dir_row_t;

    // Rows marked as typed carry the result expected straight after reset.
    localparam dir_row_t DIR_TABLE [NUM_DIR] = '{
        '{1'b1, '{lif_pkg::CMD_TICK,    8'd0,   32'd0,          32'sd0},
                '{1'b0, 32'sd0,       32'd0, 32'd0}},
        '{1'b1, '{lif_pkg::CMD_TICK,    8'd255, 32'd0,          32'sd0},
                '{1'b0, 32'sd1671270, 32'd0, 32'd0}},
        '{1'b1, '{lif_pkg::CMD_TICK,    8'd0,   32'd0,          32'sd0},
                '{1'b1, 32'sd0,       32'd1, 32'd2}},
        '{1'b1, '{lif_pkg::CMD_RECEIVE, 8'd255, 32'hFFFF_FFFF,  32'h7FFF_FFFF},
                '{1'b0, 32'sd0,       32'd1, 32'd2}},
        '{1'b1, '{lif_pkg::CMD_RECEIVE, 8'd0,   32'd15,         32'sd1},
                '{1'b0, 32'sd0,       32'd1, 32'd2}},
        '{1'b1, '{lif_pkg::CMD_RECEIVE, 8'd0,   32'd16,         32'h8000_0000},
                '{1'b0, 32'sd0,       32'd1, 32'd2}},
        '{1'b1, '{lif_pkg::CMD_RECEIVE, 8'd0,   32'd0,          32'hFFFF_FFFF},
                '{1'b0, 32'sd0,       32'd1, 32'd2}},
        '{1'b1, '{lif_pkg::CMD_TICK,    8'd255, 32'hFFFF_FFFF,  32'sd12345},
                '{1'b0, 32'sd0,       32'd1, 32'd2}},
        '{1'b0, '{lif_pkg::CMD_RECEIVE, 8'd0,   32'd3,          32'sd196608},
                '{1'b0, 32'sd0,       32'd0, 32'd0}},
        '{1'b0, '{lif_pkg::CMD_TICK,    8'd7,   32'd0,          32'sd0},
                '{1'b0, 32'sd0,       32'd0, 32'd0}},
        '{1'b0, '{lif_pkg::CMD_RECEIVE, 8'd0,   32'h8000_0004,  -32'sd5},
                '{1'b0, 32'sd0,       32'd0, 32'd0}},
        '{1'b0, '{lif_pkg::CMD_TICK,    8'd128, 32'd0,          32'sd0},
                '{1'b0, 32'sd0,       32'd0, 32'd0}}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    lif_pkg::in_item_t  in_item;
    logic               out_valid;
    logic               out_stall;
    lif_pkg::out_item_t out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [lif_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]        cfg_data;

    // Register copies for the neuron model.
    logic [16:0]        m_decay;
    logic [21:0]        m_gain;
    logic signed [31:0] m_current;
    logic signed [31:0] m_threshold;
    logic signed [31:0] m_reset_pot;
    logic [15:0]        m_refr_steps;
    logic               m_noise_en;
    logic signed [31:0] m_noise_weight;

    // Neuron state copies.
    logic signed [31:0] v_mem;
    logic               refr_flag;
    logic [15:0]        refr_cnt;
    logic [31:0]        step_cnt;
    logic [31:0]        spike_cnt;
    logic [31:0]        last_spike;
    logic signed [31:0] ring_model [RING_N];

    lif_pkg::out_item_t pending_out_q [$];
    lif_pkg::out_item_t got_res;
    lif_pkg::out_item_t exp_res;
    int                 fail_cnt;
    int unsigned        cycle_cnt;
    logic               tx_idle_on;
    logic               rx_idle_on;
    logic               hold_req;
    int                 hold_left;
    int                 stall_left;
    int                 pick;

    lif_neuron_delay_ring #(
        .RING_DEPTH (RING_N)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic logic signed [31:0] sat32(longint x);
        if (x > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (x < -longint'(64'sh8000_0000))
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    function automatic void apply_reg_write(lif_pkg::cfg_reg_e idx, logic [31:0] d);
        case (idx)
            lif_pkg::CFG_DECAY_FACTOR:     m_decay        = d[16:0];
            lif_pkg::CFG_INPUT_GAIN:       m_gain         = d[21:0];
            lif_pkg::CFG_INPUT_CURRENT:    m_current      = d;
            lif_pkg::CFG_SPIKE_THRESHOLD:  m_threshold    = d;
            lif_pkg::CFG_RESET_POTENTIAL:  m_reset_pot    = d;
            lif_pkg::CFG_REFRACTORY_STEPS: m_refr_steps   = d[15:0];
            lif_pkg::CFG_NOISE_ENABLE:     m_noise_en     = d[0];
            lif_pkg::CFG_NOISE_WEIGHT:     m_noise_weight = d;
            default: ;
        endcase
    endfunction

    function automatic lif_pkg::out_item_t neuron_update(lif_pkg::in_item_t it);
        lif_pkg::out_item_t r;
        longint    acc;
        int        slot;
        r.spiked = 1'b0;
        if (it.cmd == lif_pkg::CMD_RECEIVE)
        begin
            slot = it.arrival_time % RING_N;
            ring_model[slot] = sat32(longint'(ring_model[slot]) + longint'(it.weight));
        end
        else
        begin
            if (v_mem > m_threshold)
            begin
                refr_flag  = 1'b1;
                r.spiked   = 1'b1;
                last_spike = step_cnt;
                spike_cnt  = spike_cnt + 32'd1;
            end
            if (refr_flag)
            begin
                v_mem    = 32'sd0;
                refr_cnt = refr_cnt + 16'd1;
                if (refr_cnt > m_refr_steps)
                begin
                    v_mem     = m_reset_pot;
                    refr_cnt  = 16'd0;
                    refr_flag = 1'b0;
                end
            end
            else
            begin
                slot = step_cnt % RING_N;
                acc  = (longint'(m_decay) * longint'(v_mem)) >>> 16;
                acc  = acc + ((longint'(m_current) * longint'(m_gain)) >>> 16);
                acc  = acc + longint'(ring_model[slot]);
                if (m_noise_en)
                    acc = acc + longint'(it.noise_count) * longint'(m_noise_weight);
                v_mem = sat32(acc);
                ring_model[slot] = 32'sd0;
            end
            step_cnt = step_cnt + 32'd1;
        end
        r.potential_out   = v_mem;
        r.spike_total     = spike_cnt;
        r.last_spike_step = last_spike;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!tx_idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic offer_item(lif_pkg::in_item_t it, logic typed,
                              lif_pkg::out_item_t typed_res, int gap);
        lif_pkg::out_item_t pred;
        @(negedge clk);
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (in_stall);
        pred = neuron_update(it);
        pending_out_q.insert(pending_out_q.size(), typed ? typed_res : pred);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic write_reg(lif_pkg::cfg_reg_e idx, logic [31:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg_write(idx, d);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_out_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic report_mismatch(string field, logic [31:0] e, logic [31:0] a);
        fail_cnt++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, e, a);
    endtask

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_MAX)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            got_res = out_item;
            if (pending_out_q.size() == 0)
            begin
                fail_cnt++;
                $display("%0t: unexpected result, expected none, actual %h",
                         $time, got_res);
            end
            else
            begin
                exp_res = pending_out_q.pop_front();
                if (got_res.spiked !== exp_res.spiked)
                    report_mismatch("spiked", exp_res.spiked, got_res.spiked);
                if (got_res.potential_out !== exp_res.potential_out)
                    report_mismatch("potential_out", exp_res.potential_out,
                                    got_res.potential_out);
                if (got_res.spike_total !== exp_res.spike_total)
                    report_mismatch("spike_total", exp_res.spike_total,
                                    got_res.spike_total);
                if (got_res.last_spike_step !== exp_res.last_spike_step)
                    report_mismatch("last_spike_step", exp_res.last_spike_step,
                                    got_res.last_spike_step);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 120;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (!rx_idle_on)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                out_stall <= 1'b0;
            end
            else if (pick < 95)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = $urandom_range(10, 30);
                out_stall <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [31:0]        reg_vals [8];
        lif_pkg::in_item_t  it;
        lif_pkg::out_item_t no_res;
        int                 n_items;

        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        out_stall  = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = lif_pkg::CFG_DECAY_FACTOR;
        cfg_data   = 32'd0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        fail_cnt   = 0;
        cycle_cnt  = 0;
        no_res     = '0;

        m_decay        = lif_pkg::RST_DECAY_FACTOR;
        m_gain         = lif_pkg::RST_INPUT_GAIN;
        m_current      = lif_pkg::RST_INPUT_CURRENT;
        m_threshold    = lif_pkg::RST_SPIKE_THRESHOLD;
        m_reset_pot    = lif_pkg::RST_RESET_POTENTIAL;
        m_refr_steps   = lif_pkg::RST_REFRACTORY_STEPS;
        m_noise_en     = lif_pkg::RST_NOISE_ENABLE;
        m_noise_weight = lif_pkg::RST_NOISE_WEIGHT;
        v_mem      = 32'sd0;
        refr_flag  = 1'b0;
        refr_cnt   = 16'd0;
        step_cnt   = 32'd0;
        spike_cnt  = 32'd0;
        last_spike = 32'd0;
        for (int i = 0; i < RING_N; i++)
            ring_model[i] = 32'sd0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NUM_DIR; i++)
            offer_item(DIR_TABLE[i].item, DIR_TABLE[i].typed, DIR_TABLE[i].res, 0);
        drain();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: n_items = 150;
                1:
                begin
                    n_items  = 100;
                    reg_vals = '{32'hFFFF_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hABCD_0000,
                                 32'hFFFF_FFFF, 32'h7FFF_FFFF};
                end
                2:
                begin
                    n_items  = 100;
                    reg_vals = '{32'h0002_0000, 32'hFFC0_0000, 32'h8000_0000,
                                 32'h8000_0000, 32'h8000_0000, 32'h0000_0001,
                                 32'hFFFF_FFFE, 32'h8000_0000};
                end
                3:
                begin
                    // An all-ones refractory limit keeps the neuron refractory.
                    n_items  = 30;
                    reg_vals = '{32'd65209, 32'd6537, 32'h0002_0000,
                                 32'h0001_0000, 32'd655360, 32'h0000_FFFF,
                                 32'd1, 32'd6554};
                end
                default:
                begin
                    n_items = 125;
                    reg_vals[0] = ($urandom_range(0, 3) == 0) ?
                                  $urandom_range(0, 65536) : $urandom_range(60000, 65536);
                    reg_vals[1] = ($urandom_range(0, 3) == 0) ?
                                  $urandom : $urandom_range(0, 20000);
                    reg_vals[2] = ($urandom_range(0, 3) == 0) ?
                                  $urandom : $urandom_range(0, 20 << 16) - (10 << 16);
                    reg_vals[3] = $urandom_range(1 << 16, 30 << 16);
                    reg_vals[4] = $urandom_range(0, 20 << 16) - (10 << 16);
                    reg_vals[5] = $urandom_range(0, 25) | ($urandom & 32'hFFFF_0000);
                    reg_vals[6] = $urandom;
                    reg_vals[7] = ($urandom_range(0, 3) == 0) ?
                                  $urandom : $urandom_range(0, 1 << 16) - (1 << 15);
                end
            endcase
            if (ph > 0)
            begin
                for (int r = 0; r < 8; r++)
                    write_reg(lif_pkg::cfg_reg_e'(r), reg_vals[r]);
                @(negedge clk);
                cfg_valid <= 1'b0;
            end
            tx_idle_on = (ph % 3 != 1);
            rx_idle_on = (ph % 3 != 2);

            for (int k = 0; k < n_items; k++)
            begin
                if (ph == 4 && k == 40)
                    hold_req = 1'b1;
                it.cmd         = ($urandom_range(0, 9) < 4) ?
                                 lif_pkg::CMD_RECEIVE : lif_pkg::CMD_TICK;
                it.noise_count = ($urandom_range(0, 7) == 0) ?
                                 $urandom_range(0, 255) : $urandom_range(0, 6);
                it.arrival_time = ($urandom_range(0, 7) == 0) ?
                                  $urandom : step_cnt + $urandom_range(0, 20);
                it.weight      = ($urandom_range(0, 7) == 0) ?
                                 $urandom : $urandom_range(0, 16 << 16) - (4 << 16);
                offer_item(it, 1'b0, no_res, pick_gap());
            end
            drain();
        end

        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/lif_pkg.sv
hdl/lif_cfg_regs.sv
hdl/lif_delay_ring.sv
hdl/lif_front.sv
hdl/lif_update.sv
hdl/lif_neuron_delay_ring.sv
bench/lif_neuron_delay_ring_tb.sv
